[rtl/dssf_pkg.sv]
// Shared types, constants and the segment table of the seven-segment framer.
`default_nettype none

package dssf_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] CmdData = 8'h40;
  localparam logic [7:0] CmdAddr = 8'hC0;
  localparam logic [7:0] CmdCtrl = 8'h80;

  localparam logic [2:0] MaxDigits = 3'd4;

  localparam logic [13:0] PlaceThousand = 14'd1000;
  localparam logic [9:0]  PlaceHundred  = 10'd100;
  localparam logic [6:0]  PlaceTen      = 7'd10;

  localparam logic CfgDisplayControl = 1'b0;
  localparam logic CfgColonEnable    = 1'b1;

  typedef struct packed {
    logic [13:0] number_value;
    logic [7:0]  dot_mask;
    logic        show_leading_zeros;
    logic [2:0]  digit_count;
    logic [1:0]  start_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       frame_stop;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [3:0][7:0] seg;
    logic [2:0]      count;
    logic [1:0]      pos;
  } frame_rec_t;

  typedef struct packed {
    logic                valid;
    logic [FifoCntW-1:0] count;
  } fifo_stat_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      4'hF: seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

[rtl/dssf_front.sv]
// Front end: takes requests, splits the number into digits and builds the segment record.
`default_nettype none

module dssf_front import dssf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   in_data_i,
  input  wire logic       colon_en_i,
  input  wire fifo_stat_t fifo_stat_i,
  output logic            rec_wr_o,
  output frame_rec_t      rec_o
);

  logic       v0_q, v1_q, v2_q;
  in_item_t   s0_q;
  logic [7:0] dots1_q, dots2_q;
  logic       zeros1_q, zeros2_q;
  logic [2:0] cnt1_q, cnt2_q;
  logic [1:0] pos1_q, pos2_q;
  logic [4:0] th1_q, th2_q;
  logic [9:0] rem1_q;
  logic [3:0] hu2_q;
  logic [6:0] rem2_q;

  logic [13:0] th_r;
  logic [4:0]  th_d;
  logic [9:0]  hu_r;
  logic [3:0]  hu_d;
  logic [6:0]  te_r;
  logic [3:0]  te_d;
  logic [2:0]  cnt_sat;
  logic [2:0]  inflight;
  logic [2:0]  used;
  logic        accept;
  logic        z0, z1, z2;
  logic        blank0, blank1, blank2;
  logic [7:0]  seg0, seg1, seg2, seg3;

  assign inflight = 3'(v0_q) + 3'(v1_q) + 3'(v2_q);
  assign used     = 3'(fifo_stat_i.count) + inflight;
  assign full     = (used >= 3'(FifoDepth));
  assign accept   = push && !full;

  assign cnt_sat = (s0_q.digit_count > MaxDigits) ? MaxDigits : s0_q.digit_count;

  always_comb begin
    th_r = s0_q.number_value;
    th_d = '0;
    for (int i = 4; i >= 0; i--) begin
      if (th_r >= (PlaceThousand << i)) begin
        th_r    = th_r - (PlaceThousand << i);
        th_d[i] = 1'b1;
      end
    end
  end

  always_comb begin
    hu_r = rem1_q;
    hu_d = '0;
    for (int i = 3; i >= 0; i--) begin
      if (hu_r >= (PlaceHundred << i)) begin
        hu_r    = hu_r - (PlaceHundred << i);
        hu_d[i] = 1'b1;
      end
    end
  end

  always_comb begin
    te_r = rem2_q;
    te_d = '0;
    for (int i = 3; i >= 0; i--) begin
      if (te_r >= (PlaceTen << i)) begin
        te_r    = te_r - (PlaceTen << i);
        te_d[i] = 1'b1;
      end
    end
  end

  assign z0     = (th2_q == 5'd0);
  assign z1     = (hu2_q == 4'd0);
  assign z2     = (te_d == 4'd0);
  assign blank0 = !zeros2_q && z0;
  assign blank1 = !zeros2_q && z0 && z1;
  assign blank2 = !zeros2_q && z0 && z1 && z2;

  assign seg0 = (blank0 ? 8'h00 : seg_encode(th2_q[3:0])) | {dots2_q[7], 7'b0};
  assign seg1 = (blank1 ? 8'h00 : seg_encode(hu2_q)) | {dots2_q[6], 7'b0}
              | {(colon_en_i && (cnt2_q == MaxDigits) && (pos2_q == 2'd0)), 7'b0};
  assign seg2 = (blank2 ? 8'h00 : seg_encode(te_d)) | {dots2_q[5], 7'b0};
  assign seg3 = seg_encode(te_r[3:0]) | {dots2_q[4], 7'b0};

  assign rec_wr_o  = v2_q;
  assign rec_o.seg = {seg3, seg2, seg1, seg0};
  assign rec_o.count = cnt2_q;
  assign rec_o.pos   = pos2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_q <= in_data_i;
    end
    dots1_q  <= s0_q.dot_mask;
    zeros1_q <= s0_q.show_leading_zeros;
    cnt1_q   <= cnt_sat;
    pos1_q   <= s0_q.start_position;
    th1_q    <= th_d;
    rem1_q   <= th_r[9:0];
    dots2_q  <= dots1_q;
    zeros2_q <= zeros1_q;
    cnt2_q   <= cnt1_q;
    pos2_q   <= pos1_q;
    th2_q    <= th1_q;
    hu2_q    <= hu_d;
    rem2_q   <= hu_r[6:0];
  end

endmodule

`default_nettype wire

[rtl/dssf_fifo.sv]
// Short record queue between the digit front end and the byte sequencer.
`default_nettype none

module dssf_fifo import dssf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_i,
  input  wire frame_rec_t wr_data_i,
  input  wire logic       rd_i,
  output frame_rec_t      rd_data_o,
  output fifo_stat_t      stat_o
);

  frame_rec_t          mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;

  assign rd_data_o    = mem[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.count = cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("record queue count exceeds its depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && !rd_i && (cnt_q == FifoCntW'(FifoDepth))))
    else $error("record queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && (cnt_q == '0)))
    else $error("record queue read while empty");
`endif

endmodule

`default_nettype wire

[rtl/dssf_back.sv]
// Back end: walks one record and emits its frame bytes through an output register.
`default_nettype none

module dssf_back import dssf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire fifo_stat_t fifo_stat_i,
  input  wire frame_rec_t rec_i,
  output logic            rec_rd_o,
  input  wire logic [3:0] display_control_i,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       out_data_o
);

  logic [2:0] idx_q;
  logic       ov_q;
  out_item_t  out_q;

  logic       pop_out;
  logic       load;
  logic [2:0] last_idx;
  logic [2:0] dsel;
  out_item_t  item;

  assign pop_out  = pop && ov_q;
  assign load     = fifo_stat_i.valid && (!ov_q || pop_out);
  assign last_idx = rec_i.count + 3'd2;
  assign dsel     = idx_q + 3'd2 - rec_i.count;
  assign rec_rd_o = load && (idx_q == last_idx);

  always_comb begin
    priority if (idx_q == 3'd0) begin
      item = '{frame_byte: CmdData, frame_start: 1'b1, frame_stop: 1'b1, last: 1'b0};
    end else if (idx_q == 3'd1) begin
      item = '{frame_byte: CmdAddr | {6'b0, rec_i.pos}, frame_start: 1'b1,
               frame_stop: (rec_i.count == 3'd0), last: 1'b0};
    end else if (idx_q == last_idx) begin
      item = '{frame_byte: CmdCtrl | {4'b0, display_control_i}, frame_start: 1'b1,
               frame_stop: 1'b1, last: 1'b1};
    end else begin
      item = '{frame_byte: rec_i.seg[dsel[1:0]], frame_start: 1'b0,
               frame_stop: (idx_q == (rec_i.count + 3'd1)), last: 1'b0};
    end
  end

  assign empty      = !ov_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= rec_rd_o ? 3'd0 : idx_q + 3'd1;
      end else if (pop_out) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= item;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 3'd6)
    else $error("byte index beyond the longest frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (idx_q == 3'd0)) |=> (out_q.frame_byte == CmdData))
    else $error("frame did not open with the data command");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !pop) |=> ov_q)
    else $error("waiting byte dropped without a transaction");
`endif

endmodule

`default_nettype wire

[rtl/decimal_seven_segment_framer.sv]
// Top level of the four-digit decimal seven-segment display framer.
//
//   channel  direction  handshake                  payload
//   input    in         push / full                in_data_i   (in_item_t)
//   result   out        empty / pop                out_data_o  (out_item_t)
//   config   in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A request passes the digit pipeline registers, then waits in a four-entry queue.
// The byte sequencer emits one byte per cycle while pop is held, 3 + count bytes per
// request, so the output port sets the sustained request rate.
// Reset clears the pipeline, the queue, the sequencer and both registers; no clearing pass.
// A stalled pop holds the output register while the front takes requests until full.
`default_nettype none

module decimal_seven_segment_framer import dssf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   in_data_i,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [3:0] cfg_data_i
);

  logic [3:0] display_control_q;
  logic       colon_enable_q;
  logic       rec_wr, rec_rd;
  frame_rec_t rec_wr_data, rec_rd_data;
  fifo_stat_t fifo_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_control_q <= '0;
      colon_enable_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDisplayControl: display_control_q <= cfg_data_i;
        CfgColonEnable:    colon_enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  dssf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .colon_en_i  (colon_enable_q),
    .fifo_stat_i (fifo_stat),
    .rec_wr_o    (rec_wr),
    .rec_o       (rec_wr_data)
  );

  dssf_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_wr),
    .wr_data_i (rec_wr_data),
    .rd_i      (rec_rd),
    .rd_data_o (rec_rd_data),
    .stat_o    (fifo_stat)
  );

  dssf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fifo_stat_i       (fifo_stat),
    .rec_i             (rec_rd_data),
    .rec_rd_o          (rec_rd),
    .display_control_i (display_control_q),
    .empty             (empty),
    .pop               (pop),
    .out_data_o        (out_data_o)
  );

endmodule

`default_nettype wire

[tb/sv/dssf_frame_checker.sv]
`timescale 1ns / 100ps
// Scoreboard that predicts the framer's byte transactions and checks every one of them.
module dssf_frame_checker
  import dssf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_item_t    in_data_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam logic [15:0][7:0] SegPattern = {
    8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  out_item_t   expected_bytes[$];
  logic [3:0]  ctrl_nibble;
  logic        colon_on;
  int unsigned errors;

  function automatic out_item_t frame(input logic [7:0] data, input logic st,
                                      input logic sp, input logic ls);
    out_item_t item;
    item.frame_byte  = data;
    item.frame_start = st;
    item.frame_stop  = sp;
    item.last        = ls;
    return item;
  endfunction

  function automatic void predict_frame(input in_item_t req);
    logic [3:0][7:0] glyph;
    logic [7:0]      shown;
    logic [2:0]      cnt;
    logic            leading;
    int unsigned     rest;
    int unsigned     place;
    int unsigned     d;
    rest    = req.number_value;
    leading = 1'b1;
    cnt     = (req.digit_count > MaxDigits) ? MaxDigits : req.digit_count;
    for (int k = 0; k < 4; k++) begin
      place = (k == 0) ? 1000 : (k == 1) ? 100 : (k == 2) ? 10 : 1;
      d = rest / place;
      if (d == 0) begin
        shown = (req.show_leading_zeros || !leading || k == 3) ? SegPattern[0] : 8'h00;
      end else begin
        shown   = SegPattern[d[3:0]];
        rest    = rest - d * place;
        leading = 1'b0;
      end
      shown[7] = req.dot_mask[7 - k];
      glyph[k] = shown;
    end
    if (cnt == MaxDigits && req.start_position == 2'd0 && colon_on) begin
      glyph[1][7] = 1'b1;
    end
    expected_bytes.push_back(frame(CmdData, 1'b1, 1'b1, 1'b0));
    expected_bytes.push_back(frame(CmdAddr + req.start_position, 1'b1, cnt == 3'd0, 1'b0));
    for (int k = 4 - cnt; k < 4; k++) begin
      expected_bytes.push_back(frame(glyph[k], 1'b0, k == 3, 1'b0));
    end
    expected_bytes.push_back(frame(CmdCtrl + ctrl_nibble, 1'b1, 1'b1, 1'b1));
  endfunction

  function automatic void check_frame_byte(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected frame byte transaction: 0x%02h", got.frame_byte);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    if (got.frame_byte !== want.frame_byte) begin
      $error("frame_byte: expected 0x%02h, actual 0x%02h", want.frame_byte, got.frame_byte);
      errors++;
    end
    if (got.frame_start !== want.frame_start) begin
      $error("frame_start: expected %0b, actual %0b", want.frame_start, got.frame_start);
      errors++;
    end
    if (got.frame_stop !== want.frame_stop) begin
      $error("frame_stop: expected %0b, actual %0b", want.frame_stop, got.frame_stop);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_nibble = 4'd0;
      colon_on    = 1'b0;
      errors      = 0;
      expected_bytes.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgDisplayControl) begin
          ctrl_nibble = cfg_data_i;
        end else begin
          colon_on = cfg_data_i[0];
        end
      end
      if (pop_i && !empty_i) begin
        check_frame_byte(out_data_i);
      end
      if (push_i && !full_i) begin
        predict_frame(in_data_i);
      end
      errors_o  <= errors;
      pending_o <= expected_bytes.size();
    end
  end

endmodule

[tb/sv/tb_decimal_seven_segment_framer.sv]
`timescale 1ns / 100ps
// Testbench top that drives random and directed requests into the framer and reports the verdict.
module tb_decimal_seven_segment_framer;
  import dssf_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned PhaseItems = 64;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    req_data;
  logic        empty;
  logic        pop;
  out_item_t   frame_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [3:0]  cfg_data;
  logic        calm;
  int unsigned errors;
  int unsigned pending;
  int unsigned idle_cycles;

  decimal_seven_segment_framer u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (req_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (frame_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  dssf_frame_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push_i     (push),
    .full_i     (full),
    .in_data_i  (req_data),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_data_i (frame_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_item_t make_request(input logic [13:0] num, input logic [7:0] dots,
                                            input logic zeros, input logic [2:0] cnt,
                                            input logic [1:0] pos);
    in_item_t req;
    req.number_value       = num;
    req.dot_mask           = dots;
    req.show_leading_zeros = zeros;
    req.digit_count        = cnt;
    req.start_position     = pos;
    return req;
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    case ($urandom_range(0, 7))
      0: req.number_value = 14'($urandom_range(10000, 16383));
      1: req.number_value = 14'($urandom_range(0, 99));
      default: req.number_value = 14'($urandom_range(0, 9999));
    endcase
    req.dot_mask           = 8'($urandom);
    req.show_leading_zeros = 1'($urandom_range(0, 1));
    req.digit_count        = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                         : 3'($urandom_range(0, 4));
    req.start_position     = 2'($urandom_range(0, 3));
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push     <= 1'b1;
    req_data <= req;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_registers(input logic [3:0] ctrl, input logic colon);
    cfg_valid <= 1'b1;
    cfg_index <= CfgDisplayControl;
    cfg_data  <= ctrl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CfgColonEnable;
    cfg_data  <= {3'b000, colon};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase();
    repeat (PhaseItems) send_request(random_request());
    drain();
  endtask

  initial begin
    push      <= 1'b0;
    req_data  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CfgDisplayControl;
    cfg_data  <= 4'd0;
    rst_n     <= 1'b0;
    calm       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_registers(4'hF, 1'b1);
    send_request(make_request(14'd0, 8'h00, 1'b0, 3'd4, 2'd0));
    send_request(make_request(14'd0, 8'h00, 1'b1, 3'd4, 2'd0));
    send_request(make_request(14'd9999, 8'hFF, 1'b0, 3'd4, 2'd3));
    send_request(make_request(14'd7, 8'h80, 1'b0, 3'd4, 2'd1));
    send_request(make_request(14'd7, 8'h01, 1'b1, 3'd4, 2'd2));
    send_request(make_request(14'd100, 8'h40, 1'b0, 3'd4, 2'd0));
    send_request(make_request(14'd1005, 8'h20, 1'b0, 3'd4, 2'd0));
    send_request(make_request(14'd1234, 8'h10, 1'b0, 3'd0, 2'd0));
    send_request(make_request(14'd1234, 8'h08, 1'b0, 3'd1, 2'd3));
    send_request(make_request(14'd1234, 8'h04, 1'b0, 3'd2, 2'd2));
    send_request(make_request(14'd1234, 8'h02, 1'b0, 3'd3, 2'd1));
    send_request(make_request(14'd5678, 8'hAA, 1'b0, 3'd5, 2'd0));
    send_request(make_request(14'd5678, 8'h55, 1'b1, 3'd7, 2'd0));
    send_request(make_request(14'd42, 8'h00, 1'b0, 3'd6, 2'd2));
    send_request(make_request(14'd10000, 8'h00, 1'b0, 3'd4, 2'd0));
    send_request(make_request(14'd11999, 8'h00, 1'b0, 3'd4, 2'd1));
    send_request(make_request(14'd12345, 8'h00, 1'b1, 3'd4, 2'd0));
    send_request(make_request(14'd13000, 8'h0F, 1'b0, 3'd4, 2'd0));
    send_request(make_request(14'd14500, 8'hF0, 1'b0, 3'd4, 2'd2));
    send_request(make_request(14'd15999, 8'h00, 1'b0, 3'd4, 2'd0));
    send_request(make_request(14'd16000, 8'h00, 1'b0, 3'd4, 2'd0));
    send_request(make_request(14'd16383, 8'hFF, 1'b1, 3'd7, 2'd3));
    send_request(make_request(14'd8192, 8'h00, 1'b0, 3'd4, 2'd0));
    send_request(make_request(14'd3, 8'h00, 1'b0, 3'd0, 2'd3));
    drain();

    write_registers(4'h0, 1'b0);
    random_phase();
    write_registers(4'h8, 1'b1);
    random_phase();
    write_registers(4'h7, 1'b0);
    random_phase();
    write_registers(4'($urandom_range(0, 15)), 1'b1);
    calm = 1'b1;
    random_phase();

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    pop <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      pop <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) != 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
